// ===== rtl/wtae_pkg.sv =====
// Shared types, codes and constants for the wavetable AR envelope.
// No dependencies; compiled first.
`default_nettype none

package wtae_pkg;

  // default parameter values
  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int KIND_W   = 3;
  localparam int TSEL_W   = 2;
  localparam int TIDX_W   = 8;
  localparam int TVAL_W   = 12;
  localparam int LEVEL_W  = 16;
  localparam int STAGE_W  = 2;
  localparam int INC_W    = 24;
  localparam int BLEND_W  = 14;

  // APB
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_ATTACK_INC = 3'd0;
  localparam logic [2:0] REG_DECAY_INC  = 3'd1;
  localparam logic [2:0] REG_CYCLING    = 3'd2;
  localparam logic [2:0] REG_FULL_OPEN  = 3'd3;
  localparam logic [2:0] REG_BLEND      = 3'd4;

  localparam logic [INC_W-1:0]   INC_RST   = 24'd65536;
  localparam logic [BLEND_W-1:0] BLEND_RST = 14'd4096;
  localparam logic [BLEND_W-1:0] BLEND_HALF = 14'd4096;
  localparam logic [BLEND_W-1:0] BLEND_FULL = 14'd8192;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'd32768;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 16'd0;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ATTACK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DECAY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SYNC   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TWRITE = 3'd4;

  // shape tables
  localparam logic [TSEL_W-1:0] TBL_FALL = 2'd0;
  localparam logic [TSEL_W-1:0] TBL_TRI  = 2'd1;
  localparam logic [TSEL_W-1:0] TBL_RISE = 2'd2;

  typedef enum logic [STAGE_W-1:0] {
    STG_STOPPED = 2'd0,
    STG_ATTACK  = 2'd1,
    STG_DECAY   = 2'd2
  } stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDHI,
    ST_INTHI,
    ST_MUL,
    ST_OUT
  } fsm_t;

  typedef enum logic [1:0] {
    FORCE_NONE,
    FORCE_ZERO,
    FORCE_FULL
  } force_t;

  typedef struct packed {
    logic [INC_W-1:0]   attack_inc;
    logic [INC_W-1:0]   decay_inc;
    logic               cycling;
    logic               full_open;
    logic [BLEND_W-1:0] blend;
  } cfg_t;

  typedef struct packed {
    logic ld_lo;
    logic ld_hi;
    logic ld_blend;
  } ictl_t;

endpackage

`default_nettype wire

// ===== rtl/wtae_cfg.sv =====
// APB configuration registers of the envelope.
// Depends on wtae_pkg.
`default_nettype none

module wtae_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wtae_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wtae_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wtae_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output wtae_pkg::cfg_t                      cfg
);
  import wtae_pkg::*;

  logic [INC_W-1:0]   attack_inc_r;
  logic [INC_W-1:0]   decay_inc_r;
  logic               cycling_r;
  logic               full_open_r;
  logic [BLEND_W-1:0] blend_r;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_inc_r <= INC_RST;
      decay_inc_r  <= INC_RST;
      cycling_r    <= 1'b0;
      full_open_r  <= 1'b0;
      blend_r      <= BLEND_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK_INC: attack_inc_r <= pwdata[INC_W-1:0];
        REG_DECAY_INC:  decay_inc_r  <= pwdata[INC_W-1:0];
        REG_CYCLING:    cycling_r    <= pwdata[0];
        REG_FULL_OPEN:  full_open_r  <= pwdata[0];
        REG_BLEND:      blend_r      <= pwdata[BLEND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK_INC: prdata = CFG_DATA_W'(attack_inc_r);
      REG_DECAY_INC:  prdata = CFG_DATA_W'(decay_inc_r);
      REG_CYCLING:    prdata = CFG_DATA_W'(cycling_r);
      REG_FULL_OPEN:  prdata = CFG_DATA_W'(full_open_r);
      REG_BLEND:      prdata = CFG_DATA_W'(blend_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.attack_inc = attack_inc_r;
    cfg.decay_inc  = decay_inc_r;
    cfg.cycling    = cycling_r;
    cfg.full_open  = full_open_r;
    cfg.blend      = blend_r;
  end

endmodule

`default_nettype wire

// ===== rtl/wtae_shape_mem.sv =====
// Shape table memory: one write port, two registered read ports.
// All three tables share it, addressed by {table, index}. No dependencies.
`default_nettype none

module wtae_shape_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/wtae_interp.sv =====
// Interpolation and blend datapath: two table interpolations, blend multiply,
// rounding to Q1.15. Depends on wtae_pkg.
`default_nettype none

module wtae_interp #(
  parameter int SAMPLE_BITS   = wtae_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = wtae_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire wtae_pkg::ictl_t              ctl,
  input  wire logic [SAMPLE_BITS-1:0]       rd_a,
  input  wire logic [SAMPLE_BITS-1:0]       rd_b,
  input  wire logic [FRACTION_BITS-1:0]     frac,
  input  wire logic [wtae_pkg::BLEND_W-1:0] weight,
  output logic      [wtae_pkg::LEVEL_W-1:0] level
);
  import wtae_pkg::*;

  localparam int S_W = SAMPLE_BITS + FRACTION_BITS;  // interpolated sample
  localparam int P_W = S_W + 2;                      // signed interp sum
  localparam int M_W = S_W + BLEND_W + 2;            // signed blend sum
  localparam int N_W = S_W + BLEND_W;                // rounded blend sum
  localparam int SH  = S_W - 2;                      // to Q1.15
  localparam logic [N_W-1:0] RND = N_W'(1) << (SH - 1);

  logic signed [SAMPLE_BITS:0] dsamp;
  logic signed [P_W-1:0]       dprod;
  logic signed [P_W-1:0]       s_sum;
  logic        [S_W-1:0]       s_val;
  logic        [S_W-1:0]       s_lo_r;
  logic        [S_W-1:0]       s_hi_r;
  logic signed [S_W:0]         ds;
  logic signed [M_W-1:0]       prod_r;
  logic        [M_W-1:0]       lo_sh;
  logic signed [M_W-1:0]       nfull;
  logic        [N_W-1:0]       rnd;

  // s = a*2^F + (b-a)*frac, never negative
  always_comb begin
    dsamp = $signed({1'b0, rd_b}) - $signed({1'b0, rd_a});
    dprod = dsamp * $signed({1'b0, frac});
    s_sum = $signed({2'b00, rd_a, {FRACTION_BITS{1'b0}}}) + dprod;
    s_val = s_sum[S_W-1:0];
  end

  assign ds = $signed({1'b0, s_hi_r}) - $signed({1'b0, s_lo_r});

  always_ff @(posedge clk) begin
    if (ctl.ld_lo) begin
      s_lo_r <= s_val;
    end
    if (ctl.ld_hi) begin
      s_hi_r <= s_val;
    end
    if (ctl.ld_blend) begin
      prod_r <= ds * $signed({1'b0, weight});
    end
  end

  // n = lo*8192 + (hi-lo)*w, then round half up
  always_comb begin
    lo_sh = M_W'(s_lo_r) << (BLEND_W - 1);
    nfull = $signed(lo_sh) + prod_r;
    rnd   = nfull[N_W-1:0] + RND;
    level = rnd[N_W-1 -: LEVEL_W];
  end

endmodule

`default_nettype wire

// ===== rtl/wavetable_ar_envelope.sv =====
// Wavetable AR envelope top: phase/stage control, table memory, datapath.
// Tick: lo-table read in the accept cycle, then RDHI (hi-table read), INTHI (hi interpolation),
// MUL (blend multiply), OUT (round; waits while the sink stalls). A new request is taken in the
// cycle that loads the previous result. Other kinds complete in the accept cycle, giving no result.
// Reset: phase 0, stage decay, registers to defaults; table memory is not cleared.
// Depends on wtae_pkg, wtae_cfg, wtae_shape_mem, wtae_interp.
`default_nettype none

module wavetable_ar_envelope #(
  parameter int TABLE_DEPTH   = wtae_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS   = wtae_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = wtae_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [wtae_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [wtae_pkg::TSEL_W-1:0]     in_table_select,
  input  wire logic [wtae_pkg::TIDX_W-1:0]     in_table_index,
  input  wire logic [wtae_pkg::TVAL_W-1:0]     in_table_value,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [wtae_pkg::LEVEL_W-1:0]    out_level,
  output logic      [wtae_pkg::STAGE_W-1:0]    out_stage,
  // APB configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wtae_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wtae_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wtae_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import wtae_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int PH_W   = IDX_W + FRACTION_BITS;         // phase spans 0 to just below TABLE_DEPTH
  localparam int SUM_W  = ((PH_W > INC_W) ? PH_W : INC_W) + 1;
  localparam int MADR_W = TSEL_W + IDX_W;                // {table, index}

  cfg_t   cfg;
  ictl_t  ictl;

  // control state
  fsm_t   state_r, state_nxt;
  logic   [PH_W-1:0] phase_r, phase_nxt;
  stage_t stage_r, stage_nxt;

  // per-tick context
  force_t force_r, force_nxt;
  stage_t res_stage_r;
  logic   [TSEL_W-1:0]  hi_sel_r;
  logic   [BLEND_W-1:0] weight_r;

  // output register
  logic   out_valid_r;
  logic   [LEVEL_W-1:0] out_level_r;
  stage_t out_stage_r;

  logic   accept, tick_acc, out_free, out_load, rd_hi;
  logic   [SUM_W-1:0] ph_ext, ph_sum;
  logic   [INC_W-1:0] inc_sel;

  logic   [BLEND_W-1:0] b_sat, b_off, weight_nxt;
  logic   [TSEL_W-1:0]  lo_sel_nxt, hi_sel_nxt;

  logic   [IDX_W-1:0]   idx_rd, idx_rd1;
  logic   [MADR_W-1:0]  raddr_a, raddr_b, waddr;
  logic                 mem_we;
  logic   [TIDX_W+IDX_W-1:0]      tidx_ext;
  logic   [TVAL_W+SAMPLE_BITS-1:0] tval_ext;
  logic   [SAMPLE_BITS-1:0]       rd_a, rd_b;
  logic   [LEVEL_W-1:0]           interp_level;

  wtae_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept   = in_valid && in_ready;
  assign tick_acc = accept && (in_kind == KIND_TICK);
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE/OUT take a request and read the lo table at the new phase,
  // RDHI reads the hi table and interpolates lo, INTHI interpolates hi,
  // MUL does the blend multiply, OUT rounds into the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (tick_acc) state_nxt = ST_RDHI;
      ST_RDHI:  state_nxt = ST_INTHI;
      ST_INTHI: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = tick_acc ? ST_RDHI : ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE) || ((state_r == ST_OUT) && out_free);
    rd_hi          = (state_r == ST_RDHI);
    ictl.ld_lo     = (state_r == ST_RDHI);
    ictl.ld_hi     = (state_r == ST_INTHI);
    ictl.ld_blend  = (state_r == ST_MUL);
    out_load       = (state_r == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase and stage update. Phase wraps modulo full scale (a power of two),
  // so the wrap is the low PH_W bits and overflow is any bit above them.
  // Top phase bit clear means below the midpoint.
  // ---------------------------------------------------------------------------
  assign ph_ext  = SUM_W'(phase_r);
  assign inc_sel = (cfg.cycling && phase_r[PH_W-1]) || (!cfg.cycling && stage_r == STG_DECAY)
                   ? cfg.decay_inc : cfg.attack_inc;
  assign ph_sum  = ph_ext + SUM_W'(inc_sel);

  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    force_nxt = FORCE_NONE;
    if (accept) begin
      unique case (in_kind)
        KIND_TICK: begin
          if (cfg.full_open) begin
            force_nxt = FORCE_FULL;               // phase and stage frozen
          end else if (stage_r == STG_STOPPED) begin
            force_nxt = FORCE_ZERO;               // frozen even when cycling
          end else if (cfg.cycling) begin
            phase_nxt = ph_sum[PH_W-1:0];
          end else if (stage_r == STG_ATTACK) begin
            // climb to the midpoint, then hold
            if (!phase_r[PH_W-1]) phase_nxt = ph_sum[PH_W-1:0];
          end else begin
            // decay: jump to midpoint first, stop on running off the end
            if (!phase_r[PH_W-1]) begin
              phase_nxt = {1'b1, {(PH_W-1){1'b0}}};
            end else begin
              phase_nxt = ph_sum[PH_W-1:0];
              if (ph_sum[SUM_W-1:PH_W] != '0) stage_nxt = STG_STOPPED;
            end
          end
        end
        KIND_ATTACK: begin
          stage_nxt = STG_ATTACK;
          phase_nxt = '0;
        end
        KIND_DECAY:  stage_nxt = STG_DECAY;
        KIND_SYNC:   phase_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      stage_r <= STG_DECAY;
    end else begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Blend: position saturates at 1.0; lower half mixes falling arc into
  // triangle, upper half triangle into rising arc, weight is 2x the offset.
  // ---------------------------------------------------------------------------
  always_comb begin
    b_sat = (cfg.blend > BLEND_FULL) ? BLEND_FULL : cfg.blend;
    b_off = b_sat - BLEND_HALF;
    if (b_sat < BLEND_HALF) begin
      lo_sel_nxt = TBL_FALL;
      hi_sel_nxt = TBL_TRI;
      weight_nxt = {b_sat[BLEND_W-2:0], 1'b0};
    end else begin
      lo_sel_nxt = TBL_TRI;
      hi_sel_nxt = TBL_RISE;
      weight_nxt = {b_off[BLEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      force_r     <= force_nxt;
      res_stage_r <= stage_nxt;
      hi_sel_r    <= hi_sel_nxt;
      weight_r    <= weight_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Table memory. The lo-table read is issued in the accept cycle from the
  // updated phase; the hi-table read follows from the registered phase.
  // Index + 1 wraps at the table depth. Writes land only in idle or output
  // cycles, after the reads of any tick in flight.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (rd_hi) begin
      idx_rd  = phase_r[PH_W-1:FRACTION_BITS];
      raddr_a = {hi_sel_r, idx_rd};
    end else begin
      idx_rd  = phase_nxt[PH_W-1:FRACTION_BITS];
      raddr_a = {lo_sel_nxt, idx_rd};
    end
    idx_rd1 = idx_rd + IDX_W'(1);
    raddr_b = {raddr_a[MADR_W-1:IDX_W], idx_rd1};
  end

  assign tidx_ext = (TIDX_W+IDX_W)'(in_table_index);
  assign tval_ext = (TVAL_W+SAMPLE_BITS)'(in_table_value);
  assign waddr    = {in_table_select, tidx_ext[IDX_W-1:0]};
  assign mem_we   = accept && (in_kind == KIND_TWRITE) && (in_table_select <= TBL_RISE);

  wtae_shape_mem #(
    .ADDR_W (MADR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (tval_ext[SAMPLE_BITS-1:0]),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  wtae_interp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk    (clk),
    .ctl    (ictl),
    .rd_a   (rd_a),
    .rd_b   (rd_b),
    .frac   (phase_r[FRACTION_BITS-1:0]),
    .weight (weight_r),
    .level  (interp_level)
  );

  // ---------------------------------------------------------------------------
  // Output register: holds a result while the sink stalls, so the next
  // request can enter as soon as the result is loaded.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stage_r <= res_stage_r;
      unique case (force_r)
        FORCE_FULL: out_level_r <= LEVEL_FULL;
        FORCE_ZERO: out_level_r <= LEVEL_ZERO;
        default:    out_level_r <= interp_level;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_stage = out_stage_r;

endmodule

`default_nettype wire

// ===== rtl/wtae_checker.sv =====
// Port-level checks for the wavetable AR envelope, bound to the top level.
// Depends on wtae_pkg and wavetable_ar_envelope.
`default_nettype none

module wtae_assert (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [wtae_pkg::KIND_W-1:0]     in_kind,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [wtae_pkg::LEVEL_W-1:0]    out_level,
  input wire logic [wtae_pkg::STAGE_W-1:0]    out_stage
);
  import wtae_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_stage))
    else $error("stalled result changed");

  // level never exceeds 1.0
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= LEVEL_FULL)
    else $error("level above full scale");

  // a tick occupies the datapath: no request taken in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_TICK |=> !in_ready)
    else $error("request taken while tick in flight");

endmodule

bind wavetable_ar_envelope wtae_assert u_wtae_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_level (out_level),
  .out_stage (out_stage)
);

`default_nettype wire

// ===== bench/wtae_checker.sv =====
`timescale 1ns / 1ps
// Checker for wavetable_ar_envelope: watches request, result and APB ports, predicts every
// tick's level and stage and compares them in order. Depends on wtae_pkg only.

module wtae_checker
  import wtae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [TSEL_W-1:0]     in_table_select,
  input  logic [TIDX_W-1:0]     in_table_index,
  input  logic [TVAL_W-1:0]     in_table_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [LEVEL_W-1:0]    out_level,
  input  logic [STAGE_W-1:0]    out_stage,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked
);

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int FRAC_W      = FRACTION_BITS_DEF;
  localparam int PHASE_W     = INC_W;
  localparam int LEVEL_SHIFT = SAMPLE_BITS_DEF + FRAC_W - 2;
  localparam longint ROUND_BIAS = longint'(1) << (LEVEL_SHIFT - 1);
  localparam logic [PHASE_W-1:0] HALF_SCALE = PHASE_W'((DEPTH / 2) << FRAC_W);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [STAGE_W-1:0] stage;
  } level_out_t;

  level_out_t levels_due[$];

  // shadow registers
  logic [INC_W-1:0]   att_inc;
  logic [INC_W-1:0]   dec_inc;
  logic               cyc_on;
  logic               open_on;
  logic [BLEND_W-1:0] blend_pos;

  // envelope state
  logic [PHASE_W-1:0] env_phase;
  stage_t             env_stage;
  logic [TVAL_W-1:0]  shape_mem [0:2][0:DEPTH-1];

  task automatic flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t wtae_checker: %s", $time, msg);
  endtask

  // exact linear interpolation between idx and idx+1 (wrapping), scaled by 2^FRAC_W
  function automatic longint lerp_shape(input int tsel, input int idx, input longint frac);
    longint a;
    longint b;
    a = shape_mem[tsel][idx];
    b = shape_mem[tsel][(idx + 1) % DEPTH];
    return (a << FRAC_W) + (b - a) * frac;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_from_phase();
    int                 idx;
    int                 lo_sel;
    int                 hi_sel;
    longint             frac;
    longint             w;
    longint             lo;
    longint             hi;
    longint             n;
    logic [BLEND_W-1:0] b;
    idx  = int'(env_phase[PHASE_W-1:FRAC_W]);
    frac = env_phase[FRAC_W-1:0];
    b    = (blend_pos > BLEND_FULL) ? BLEND_FULL : blend_pos;
    if (b < BLEND_HALF) begin
      lo_sel = TBL_FALL;
      hi_sel = TBL_TRI;
      w = b;
    end else begin
      lo_sel = TBL_TRI;
      hi_sel = TBL_RISE;
      w = b - BLEND_HALF;
    end
    w  = 2 * w;
    lo = lerp_shape(lo_sel, idx, frac);
    hi = lerp_shape(hi_sel, idx, frac);
    n  = lo * longint'(BLEND_FULL) + (hi - lo) * w;
    if (n < 0) n = 0;
    n = (n + ROUND_BIAS) >> LEVEL_SHIFT;
    return n[LEVEL_W-1:0];
  endfunction

  task automatic predict_request(input logic [KIND_W-1:0] k, input logic [TSEL_W-1:0] s,
                                 input logic [TIDX_W-1:0] ix, input logic [TVAL_W-1:0] v);
    level_out_t       r;
    logic [PHASE_W:0] nxt;
    case (k)
      KIND_ATTACK: begin
        env_stage = STG_ATTACK;
        env_phase = '0;
      end
      KIND_DECAY: env_stage = STG_DECAY;
      KIND_SYNC: env_phase = '0;
      KIND_TWRITE: if (s <= TBL_RISE) shape_mem[s][ix] = v;
      KIND_TICK: begin
        if (open_on) begin
          r.level = LEVEL_FULL;
        end else if (env_stage == STG_STOPPED) begin
          r.level = LEVEL_ZERO;
        end else begin
          if (cyc_on) begin
            nxt = env_phase + ((env_phase < HALF_SCALE) ? att_inc : dec_inc);
            env_phase = nxt[PHASE_W-1:0];
          end else if (env_stage == STG_ATTACK) begin
            if (env_phase < HALF_SCALE) begin
              nxt = env_phase + att_inc;
              env_phase = nxt[PHASE_W-1:0];
            end
          end else begin
            // decay: snap to midpoint first, stop when running past the end
            if (env_phase < HALF_SCALE) nxt = {1'b0, HALF_SCALE};
            else nxt = env_phase + dec_inc;
            if (nxt[PHASE_W]) env_stage = STG_STOPPED;
            env_phase = nxt[PHASE_W-1:0];
          end
          r.level = level_from_phase();
        end
        r.stage = env_stage;
        levels_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_image(input logic [2:0] ridx);
    case (ridx)
      REG_ATTACK_INC: return CFG_DATA_W'(att_inc);
      REG_DECAY_INC:  return CFG_DATA_W'(dec_inc);
      REG_CYCLING:    return CFG_DATA_W'(cyc_on);
      REG_FULL_OPEN:  return CFG_DATA_W'(open_on);
      REG_BLEND:      return CFG_DATA_W'(blend_pos);
      default:        return '0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    level_out_t due;
    logic [2:0] ridx;
    if (!rst_n) begin
      att_inc   = INC_RST;
      dec_inc   = INC_RST;
      cyc_on    = 1'b0;
      open_on   = 1'b0;
      blend_pos = BLEND_RST;
      env_phase = '0;
      env_stage = STG_DECAY;
      levels_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          flag_mismatch($sformatf("level %0d stage %0d with no tick pending",
                                  out_level, out_stage));
        end else begin
          due = levels_due.pop_front();
          results_checked++;
          if (out_level !== due.level)
            flag_mismatch($sformatf("level expected %0d got %0d", due.level, out_level));
          if (out_stage !== due.stage)
            flag_mismatch($sformatf("stage expected %0d got %0d", due.stage, out_stage));
        end
      end
      if (in_valid && in_ready)
        predict_request(in_kind, in_table_select, in_table_index, in_table_value);
      if (psel && penable && pready) begin
        ridx = paddr[CFG_ADDR_W-1:2];
        if (pwrite) begin
          case (ridx)
            REG_ATTACK_INC: att_inc   = pwdata[INC_W-1:0];
            REG_DECAY_INC:  dec_inc   = pwdata[INC_W-1:0];
            REG_CYCLING:    cyc_on    = pwdata[0];
            REG_FULL_OPEN:  open_on   = pwdata[0];
            REG_BLEND:      blend_pos = pwdata[BLEND_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_image(ridx)) begin
          flag_mismatch($sformatf("register %0d read expected %0d got %0d",
                                  ridx, reg_image(ridx), prdata));
        end
      end
    end
    pending = levels_due.size();
  end

endmodule

// ===== bench/tb_wavetable_ar_envelope.sv =====
`timescale 1ns / 1ps
// Top-level bench for wavetable_ar_envelope: clock, reset, request/result/APB stimulus and verdict.
// Depends on wtae_pkg, the block's RTL and wtae_checker, which does prediction and comparison.

module tb_wavetable_ar_envelope;
  import wtae_pkg::*;

  localparam int CLK_HALF_NS   = 2;
  localparam int LIMIT_NS      = 4_000_000;  // far above the slowest clean run
  localparam int ITEM_BUDGET   = 1050;       // requests over the whole run, table fill included
  localparam int PHASES        = 8;          // register settings in the random part
  localparam int HOLD_CYCLES   = 300;        // long result-side hold-off
  localparam int SETTLE_CYCLES = 8;          // quiet time after the last level in settle()
  localparam int DRAIN_LIMIT   = 20000;
  localparam logic [TSEL_W-1:0]  TBL_UNUSED = 2'd3;  // select code with no table
  localparam int                 KIND_TOP   = (1 << KIND_W) - 1;
  localparam logic [INC_W-1:0]   INC_MAX    = '1;
  localparam logic [BLEND_W-1:0] BLEND_MAX  = '1;   // above full scale, saturates

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind;
  logic [TSEL_W-1:0]     in_table_select;
  logic [TIDX_W-1:0]     in_table_index;
  logic [TVAL_W-1:0]     in_table_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [LEVEL_W-1:0]    out_level;
  logic [STAGE_W-1:0]    out_stage;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_checked;

  // stimulus bookkeeping
  bit calm        = 1'b0;  // no idling on either side while set
  int stall_asked = 0;     // bumped by the main flow to ask for a long hold-off
  int stall_done  = 0;
  int sent        = 0;
  int work_sent   = 0;     // requests that are not ignored by the block
  int settings_used = 0;

  wavetable_ar_envelope i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_table_select (in_table_select),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_stage       (out_stage),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  wtae_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_table_select (in_table_select),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_stage       (out_stage),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #LIMIT_NS;
    $display("tb_wavetable_ar_envelope: errors");
    $finish;
  end

  // Result side: ready drops in about a third of the cycles, never while calm is set.
  // On request it holds ready low for a long stretch so the block backs up into its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_done) begin
        stall_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  // One request. Starts at a falling edge, returns at the rising edge that took it;
  // valid stays high so a following request can go straight out with a new payload.
  task automatic send_req(input logic [KIND_W-1:0] k, input logic [TSEL_W-1:0] s,
                          input logic [TIDX_W-1:0] ix, input logic [TVAL_W-1:0] v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 33) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_table_select <= s;
    in_table_index  <= ix;
    in_table_value  <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (k < KIND_TWRITE || (k == KIND_TWRITE && s != TBL_UNUSED)) work_sent++;
  endtask

  // non-write request; the unused fields carry random junk
  task automatic send_kind(input logic [KIND_W-1:0] k);
    send_req(k, TSEL_W'($urandom), TIDX_W'($urandom), TVAL_W'($urandom));
  endtask

  task automatic twrite(input logic [TSEL_W-1:0] s, input logic [TIDX_W-1:0] ix,
                        input logic [TVAL_W-1:0] v);
    send_req(KIND_TWRITE, s, ix, v);
  endtask

  // APB setup + access; the checker compares read data against its shadow registers
  task automatic apb_access(input logic wr, input logic [2:0] ridx,
                            input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {ridx, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    for (int r = REG_ATTACK_INC; r <= REG_BLEND; r++) apb_access(1'b0, 3'(r), '0);
  endtask

  // sender pause: drop valid, wait for every predicted level, then let the pipe go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [INC_W-1:0] att, input logic [INC_W-1:0] dec,
                               input logic cyc, input logic opn,
                               input logic [BLEND_W-1:0] bl);
    apb_access(1'b1, REG_ATTACK_INC, CFG_DATA_W'(att));
    apb_access(1'b1, REG_DECAY_INC, CFG_DATA_W'(dec));
    apb_access(1'b1, REG_CYCLING, CFG_DATA_W'(cyc));
    apb_access(1'b1, REG_FULL_OPEN, CFG_DATA_W'(opn));
    apb_access(1'b1, REG_BLEND, CFG_DATA_W'(bl));
    read_all_regs();
    settings_used++;
  endtask

  // mostly moderate steps so short notes cross many table positions, now and then extremes
  function automatic logic [INC_W-1:0] pick_inc();
    case ($urandom_range(9))
      0:       return '0;
      1:       return INC_MAX;
      2:       return INC_W'($urandom);
      default: return INC_W'($urandom_range(24'h004000, 24'h100000));
    endcase
  endfunction

  function automatic logic [BLEND_W-1:0] pick_blend();
    if ($urandom_range(1)) return BLEND_W'($urandom_range(0, BLEND_MAX));
    return BLEND_W'($urandom_range(0, BLEND_FULL));
  endfunction

  // filler inside a note: mostly ticks, with table rewrites, syncs and ignored requests
  task automatic spice_or_tick();
    int r;
    r = $urandom_range(99);
    if (r < 88) send_kind(KIND_TICK);
    else if (r < 92)
      twrite(TSEL_W'($urandom_range(TBL_FALL, TBL_RISE)), TIDX_W'($urandom), TVAL_W'($urandom));
    else if (r < 95) send_kind(KIND_SYNC);
    else if (r < 97) send_kind(KIND_W'($urandom_range(KIND_TWRITE + 1, KIND_TOP)));
    else twrite(TBL_UNUSED, TIDX_W'($urandom), TVAL_W'($urandom));
  endtask

  // a well-formed note: attack, some ticks, decay, more ticks (often into the stopped stage)
  task automatic play_note();
    int n_att;
    int n_dec;
    n_att = $urandom_range(0, 12);
    n_dec = $urandom_range(0, 24);
    send_kind(KIND_ATTACK);
    repeat (n_att) spice_or_tick();
    send_kind(KIND_DECAY);
    repeat (n_dec) spice_or_tick();
  endtask

  initial begin
    int                 target;
    int                 drain;
    logic [INC_W-1:0]   att;
    logic [INC_W-1:0]   dec;
    logic [BLEND_W-1:0] bl;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_TICK;
    in_table_select = TBL_FALL;
    in_table_index  = '0;
    in_table_value  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset values of every register
    read_all_regs();

    // Fill all three shape tables before any tick can read them; entries 0 and 1
    // carry the value extremes so interpolation across full swings is seen early.
    for (int t = TBL_FALL; t <= TBL_RISE; t++) begin
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
        if (i == 0) twrite(TSEL_W'(t), TIDX_W'(i), '1);
        else if (i == 1) twrite(TSEL_W'(t), TIDX_W'(i), '0);
        else twrite(TSEL_W'(t), TIDX_W'(i), TVAL_W'($urandom));
      end
    end

    // ---- directed part ----
    // out of reset the stage is decay at phase 0: first tick snaps to the midpoint
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);
    // value and index extremes, right where the next ticks land
    twrite(TBL_TRI, 8'd130, '1);
    twrite(TBL_TRI, 8'd131, '0);
    twrite(TBL_RISE, '1, '1);
    twrite(TBL_FALL, '0, '0);
    // ignored: select with no table, and the unused kinds
    twrite(TBL_UNUSED, 8'd131, '1);
    for (int k = KIND_TWRITE + 1; k <= KIND_TOP; k++) send_kind(KIND_W'(k));
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);
    // hard sync drops the phase, decay snaps back to the midpoint
    send_kind(KIND_SYNC);
    send_kind(KIND_TICK);
    // attack restarts from zero
    send_kind(KIND_ATTACK);
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);

    // decay with the largest step runs off the end: wrapped level, then stopped at zero;
    // blend above full scale saturates
    settle();
    apb_access(1'b1, REG_DECAY_INC, CFG_DATA_W'(INC_MAX));
    apb_access(1'b1, REG_BLEND, CFG_DATA_W'(BLEND_MAX));
    send_kind(KIND_DECAY);
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);

    // full open overrides the stopped stage and keeps reporting the current stage
    settle();
    apb_access(1'b1, REG_FULL_OPEN, CFG_DATA_W'(1'b1));
    send_kind(KIND_TICK);
    send_kind(KIND_ATTACK);
    send_kind(KIND_TICK);

    // cycling with the largest attack step wraps the phase around full scale
    settle();
    apply_setting(INC_MAX, INC_RST, 1'b1, 1'b0, '0);
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);

    // ---- random part ----
    // Each phase pauses the sender until all levels are in, reprograms every register
    // and then plays notes with random content until its share of the request budget
    // is spent; now and then a request is pure noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      att = pick_inc();
      dec = pick_inc();
      bl  = pick_blend();
      case (ph)
        1: begin
          att = '0;
          dec = INC_MAX;
          bl  = '0;
        end
        3: bl = BLEND_FULL;
        5: bl = BLEND_MAX;
        6: att = INC_MAX;
        7: begin
          att = INC_RST;
          dec = INC_RST;
          bl  = BLEND_RST;
        end
        default: ;
      endcase
      apply_setting(att, dec, ph == 2 || ph == 6, ph == 4, bl);
      calm = (ph == 3);             // one long stretch with no idling at all
      if (ph == 5) stall_asked++;   // result side backs off while requests keep coming
      target = sent + (ITEM_BUDGET - sent) / (PHASES - ph);
      while (sent < target) begin
        if ($urandom_range(99) < 85) play_note();
        else send_req(KIND_W'($urandom), TSEL_W'($urandom), TIDX_W'($urandom),
                      TVAL_W'($urandom));
      end
    end

    // ---- drain and verdict ----
    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (pending != 0)
      $display("tb_wavetable_ar_envelope: %0d predicted levels never came out", pending);
    $display("tb_wavetable_ar_envelope: %0d requests (%0d effective), %0d levels compared",
             sent, work_sent, results_checked);
    $display("tb_wavetable_ar_envelope: %0d register settings incl. cycling, full open, %s",
             settings_used, "saturated blend and long result back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_wavetable_ar_envelope: clean");
    end else begin
      $display("tb_wavetable_ar_envelope: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wtae_pkg.sv
rtl/wtae_cfg.sv
rtl/wtae_shape_mem.sv
rtl/wtae_interp.sv
rtl/wavetable_ar_envelope.sv
rtl/wtae_checker.sv
bench/wtae_checker.sv
bench/tb_wavetable_ar_envelope.sv
